FILE: hdl/vrtp_pkg.sv
// ----------------------------------------------------------------------------
// vrtp_pkg
// Shared types, flag positions and the reciprocal seed table for the
// vertex rotate, translate and project pipeline.
// ----------------------------------------------------------------------------
package vrtp_pkg;

    // reciprocal seed table geometry
    localparam int RECIP_TABLE_ENTRIES = 257;
    localparam int RECIP_IDX_W         = 9;

    // register indexes of the configuration port
    localparam logic [3:0] REG_ROT_ROW0   = 4'd0;
    localparam logic [3:0] REG_ROT_ROW1   = 4'd1;
    localparam logic [3:0] REG_ROT_ROW2   = 4'd2;
    localparam logic [3:0] REG_TRANS_XY   = 4'd3;
    localparam logic [3:0] REG_TRANS_Z    = 4'd4;
    localparam logic [3:0] REG_SCREEN_OFS = 4'd5;
    localparam logic [3:0] REG_DIST_SLOPE = 4'd6;
    localparam logic [3:0] REG_CUE_BIAS   = 4'd7;

    // flag word bit positions
    localparam int FLAG_ACC_POS   = 30;  // minus row
    localparam int FLAG_ACC_NEG   = 27;  // minus row
    localparam int FLAG_IR        = 24;  // minus row
    localparam int FLAG_SZ        = 18;
    localparam int FLAG_DIV       = 17;
    localparam int FLAG_MAC0_POS  = 16;
    localparam int FLAG_MAC0_NEG  = 15;
    localparam int FLAG_SX        = 14;
    localparam int FLAG_SY        = 13;
    localparam int FLAG_IR0       = 12;
    localparam int FLAG_SUMMARY   = 31;
    localparam logic [31:0] FLAG_SUMMARY_MASK = 32'h7f87e000;

    localparam logic [16:0] RATIO_MAX = 17'h1ffff;

    typedef logic [7:0] t_rom_arr [0:RECIP_TABLE_ENTRIES-1];

    // newton refined seed for divisor 0x8000 + k*0x80
    function automatic t_rom_arr build_recip_rom();
        t_rom_arr    rom;
        logic [31:0] x;
        logic [31:0] d7;
        int          k;
        for (int idx = 0; idx < RECIP_TABLE_ENTRIES; idx++) begin
            k = idx;
            if (k == RECIP_TABLE_ENTRIES - 1) begin
                k = RECIP_TABLE_ENTRIES - 2;
            end
            d7 = 32'h100 + 32'(k);
            x  = 32'd512;
            for (int i = 1; i < 5; i++) begin
                x = (x * (32'd524288 - d7 * x)) >> 18;
            end
            rom[idx] = 8'(((x + 32'd1) >> 1) - 32'h101);
        end
        return rom;
    endfunction

    localparam t_rom_arr RECIP_ROM = build_recip_rom();

    // transformed vertex travelling down the pipeline
    typedef struct packed {
        logic               valid;
        logic signed [43:0] view_x;
        logic signed [43:0] view_y;
        logic signed [43:0] view_z;
        logic signed [15:0] ir_x;
        logic signed [15:0] ir_y;
        logic signed [15:0] ir_z;
        logic [15:0]        sz;
        logic [31:0]        flags;
    } t_xform;

    // transformed vertex plus projection ratio
    typedef struct packed {
        t_xform      xf;
        logic [16:0] ratio;
    } t_div;

endpackage

FILE: hdl/vrtp_transform.sv
// ----------------------------------------------------------------------------
// vrtp_transform
// Matrix products, 44-bit wrapping accumulation, IR clamp and SZ saturation.
// Four register stages.
// ----------------------------------------------------------------------------
module vrtp_transform (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [15:0]   i_vertex_x,
    input  logic signed [15:0]   i_vertex_y,
    input  logic signed [15:0]   i_vertex_z,
    input  logic                 i_fraction_shift,
    input  logic                 i_limit_mode,
    input  logic [47:0]          i_row0,
    input  logic [47:0]          i_row1,
    input  logic [47:0]          i_row2,
    input  logic signed [31:0]   i_tx,
    input  logic signed [31:0]   i_ty,
    input  logic signed [31:0]   i_tz,
    output vrtp_pkg::t_xform     o_xf
);
    import vrtp_pkg::*;

    logic [47:0]        w_row [3];
    logic signed [15:0] w_vtx [3];
    logic signed [31:0] w_t   [3];

    // stage 1
    logic               r_v1, r_sh1, r_lm1;
    logic signed [31:0] r_p1 [3][3];
    // stage 2
    logic               r_v2, r_sh2, r_lm2;
    logic signed [31:0] r_p2 [3];
    logic signed [43:0] r_a2 [3];
    logic [31:0]        r_f2;
    logic signed [43:0] n_a2 [3];
    logic [31:0]        n_f2;
    // stage 3
    logic               r_v3, r_sh3, r_lm3;
    logic signed [43:0] r_a3 [3];
    logic [31:0]        r_f3;
    logic signed [43:0] n_a3 [3];
    logic [31:0]        n_f3;
    // stage 4
    t_xform             r_xf;
    t_xform             n_xf;

    assign w_row[0] = i_row0;
    assign w_row[1] = i_row1;
    assign w_row[2] = i_row2;
    assign w_vtx[0] = i_vertex_x;
    assign w_vtx[1] = i_vertex_y;
    assign w_vtx[2] = i_vertex_z;
    assign w_t[0]   = i_tx;
    assign w_t[1]   = i_ty;
    assign w_t[2]   = i_tz;

    // stage 1: nine matrix products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_sh1 <= i_fraction_shift;
        r_lm1 <= i_limit_mode;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_p1[r][c] <= $signed(w_row[r][16*c +: 16]) * w_vtx[c];
            end
        end
    end

    // stage 2: translation plus first two products
    always_comb begin
        logic signed [44:0] s;
        logic signed [43:0] a;
        n_f2 = '0;
        for (int r = 0; r < 3; r++) begin
            s = $signed({w_t[r][31], w_t[r], 12'd0}) + 45'(r_p1[r][0]);
            if (!s[44] && s[43]) n_f2[FLAG_ACC_POS-r] = 1'b1;
            if (s[44] && !s[43]) n_f2[FLAG_ACC_NEG-r] = 1'b1;
            a = s[43:0];
            s = 45'(a) + 45'(r_p1[r][1]);
            if (!s[44] && s[43]) n_f2[FLAG_ACC_POS-r] = 1'b1;
            if (s[44] && !s[43]) n_f2[FLAG_ACC_NEG-r] = 1'b1;
            n_a2[r] = s[43:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_sh2 <= r_sh1;
        r_lm2 <= r_lm1;
        r_f2  <= n_f2;
        for (int r = 0; r < 3; r++) begin
            r_a2[r] <= n_a2[r];
            r_p2[r] <= r_p1[r][2];
        end
    end

    // stage 3: last product
    always_comb begin
        logic signed [44:0] s;
        n_f3 = r_f2;
        for (int r = 0; r < 3; r++) begin
            s = 45'(r_a2[r]) + 45'(r_p2[r]);
            if (!s[44] && s[43]) n_f3[FLAG_ACC_POS-r] = 1'b1;
            if (s[44] && !s[43]) n_f3[FLAG_ACC_NEG-r] = 1'b1;
            n_a3[r] = s[43:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_sh3 <= r_sh2;
        r_lm3 <= r_lm2;
        r_f3  <= n_f3;
        for (int r = 0; r < 3; r++) begin
            r_a3[r] <= n_a3[r];
        end
    end

    // stage 4: shift, clamp to ir, saturate sz
    always_comb begin
        logic signed [31:0] mac [3];
        logic signed [31:0] fv;
        logic signed [31:0] lo;
        logic signed [15:0] ir [3];
        logic signed [31:0] zs;
        logic [31:0]        fl;
        fl = r_f3;
        lo = r_lm3 ? 32'sd0 : -32'sd32768;
        for (int r = 0; r < 3; r++) begin
            mac[r] = r_sh3 ? r_a3[r][43:12] : r_a3[r][31:0];
            fv = (r == 2) ? r_a3[r][43:12] : mac[r];
            if (fv < -32'sd32768 || fv > 32'sd32767) fl[FLAG_IR-r] = 1'b1;
            if (mac[r] < lo) begin
                ir[r] = lo[15:0];
            end else if (mac[r] > 32'sd32767) begin
                ir[r] = 16'sh7fff;
            end else begin
                ir[r] = mac[r][15:0];
            end
        end
        zs = r_a3[2][43:12];
        n_xf.valid  = r_v3;
        n_xf.view_x = r_a3[0];
        n_xf.view_y = r_a3[1];
        n_xf.view_z = r_a3[2];
        n_xf.ir_x   = ir[0];
        n_xf.ir_y   = ir[1];
        n_xf.ir_z   = ir[2];
        if (zs < 32'sd0) begin
            n_xf.sz = 16'd0;
            fl[FLAG_SZ] = 1'b1;
        end else if (zs > 32'sd65535) begin
            n_xf.sz = 16'hffff;
            fl[FLAG_SZ] = 1'b1;
        end else begin
            n_xf.sz = zs[15:0];
        end
        n_xf.flags = fl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xf.valid <= 1'b0;
        end else begin
            r_xf.valid <= n_xf.valid;
        end
        r_xf.view_x <= n_xf.view_x;
        r_xf.view_y <= n_xf.view_y;
        r_xf.view_z <= n_xf.view_z;
        r_xf.ir_x   <= n_xf.ir_x;
        r_xf.ir_y   <= n_xf.ir_y;
        r_xf.ir_z   <= n_xf.ir_z;
        r_xf.sz     <= n_xf.sz;
        r_xf.flags  <= n_xf.flags;
    end

    assign o_xf = r_xf;

endmodule

FILE: hdl/vrtp_divide.sv
// ----------------------------------------------------------------------------
// vrtp_divide
// H / SZ through normalization, a reciprocal seed table and one newton step.
// Five register stages, at most one multiplier per stage.
// ----------------------------------------------------------------------------
module vrtp_divide (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  vrtp_pkg::t_xform     i_xf,
    input  logic [15:0]          i_h,
    output vrtp_pkg::t_div       o_div
);
    import vrtp_pkg::*;

    // stage 5
    t_xform      r_xf5;
    logic        r_ovf5;
    logic [30:0] r_num5;
    logic [15:0] r_den5;
    logic [9:0]  r_x5;
    // stage 6
    t_xform             r_xf6;
    logic               r_ovf6;
    logic [30:0]        r_num6;
    logic [9:0]         r_x6;
    logic signed [18:0] r_t6;
    // stage 7
    t_xform             r_xf7;
    logic               r_ovf7;
    logic [30:0]        r_num7;
    logic signed [22:0] r_rc7;
    // stage 8
    t_xform      r_xf8;
    logic        r_ovf8;
    logic [31:0] r_res8;
    // stage 9
    t_div        r_out;

    logic [30:0] s5_num;
    logic [15:0] s5_den;
    logic [9:0]  s5_x;
    logic        s5_ovf;

    // stage 5: overflow test, normalize, seed lookup
    always_comb begin : s5_comb
        logic [3:0]             sh;
        logic [15:0]            den;
        logic [15:0]            sum;
        logic [RECIP_IDX_W-1:0] idx;
        sh = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (i_xf.sz[i]) sh = 4'(15 - i);
        end
        den = (i_xf.sz << sh) | 16'h8000;
        sum = {1'b0, den[14:0]} + 16'h0040;
        idx = sum[15:7];
        s5_num = 31'(i_h) << sh;
        s5_den = den;
        s5_x   = 10'h101 + 10'(RECIP_ROM[idx]);
        s5_ovf = ({i_xf.sz, 1'b0} <= {1'b0, i_h});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xf5.valid <= 1'b0;
        end else begin
            r_xf5.valid <= i_xf.valid;
        end
        r_xf5.view_x <= i_xf.view_x;
        r_xf5.view_y <= i_xf.view_y;
        r_xf5.view_z <= i_xf.view_z;
        r_xf5.ir_x   <= i_xf.ir_x;
        r_xf5.ir_y   <= i_xf.ir_y;
        r_xf5.ir_z   <= i_xf.ir_z;
        r_xf5.sz     <= i_xf.sz;
        r_xf5.flags  <= i_xf.flags | (s5_ovf ? (32'd1 << FLAG_DIV) : 32'd0);
        r_ovf5 <= s5_ovf;
        r_num5 <= s5_num;
        r_den5 <= s5_den;
        r_x5   <= s5_x;
    end

    // stage 6: t = (0x80 - d * x) >> 8
    logic [25:0]        s6_dx;
    logic signed [27:0] s6_m;
    assign s6_dx = r_den5 * r_x5;
    assign s6_m  = 28'sh80 - $signed({2'b00, s6_dx});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xf6.valid <= 1'b0;
        end else begin
            r_xf6.valid <= r_xf5.valid;
        end
        r_xf6.view_x <= r_xf5.view_x;
        r_xf6.view_y <= r_xf5.view_y;
        r_xf6.view_z <= r_xf5.view_z;
        r_xf6.ir_x   <= r_xf5.ir_x;
        r_xf6.ir_y   <= r_xf5.ir_y;
        r_xf6.ir_z   <= r_xf5.ir_z;
        r_xf6.sz     <= r_xf5.sz;
        r_xf6.flags  <= r_xf5.flags;
        r_ovf6 <= r_ovf5;
        r_num6 <= r_num5;
        r_x6   <= r_x5;
        r_t6   <= 19'(s6_m >>> 8);
    end

    // stage 7: reciprocal = (x * (2^17 + t) + 0x80) >> 8
    logic signed [19:0] s7_s;
    logic signed [31:0] s7_m;
    assign s7_s = 20'sd131072 + 20'(r_t6);
    assign s7_m = $signed({1'b0, r_x6}) * s7_s + 32'sh80;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xf7.valid <= 1'b0;
        end else begin
            r_xf7.valid <= r_xf6.valid;
        end
        r_xf7.view_x <= r_xf6.view_x;
        r_xf7.view_y <= r_xf6.view_y;
        r_xf7.view_z <= r_xf6.view_z;
        r_xf7.ir_x   <= r_xf6.ir_x;
        r_xf7.ir_y   <= r_xf6.ir_y;
        r_xf7.ir_z   <= r_xf6.ir_z;
        r_xf7.sz     <= r_xf6.sz;
        r_xf7.flags  <= r_xf6.flags;
        r_ovf7 <= r_ovf6;
        r_num7 <= r_num6;
        r_rc7  <= 23'(s7_m >>> 8);
    end

    // stage 8: numerator times reciprocal, rounded
    logic signed [55:0] s8_p;
    assign s8_p = $signed({1'b0, r_num7}) * r_rc7 + 56'sd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xf8.valid <= 1'b0;
        end else begin
            r_xf8.valid <= r_xf7.valid;
        end
        r_xf8.view_x <= r_xf7.view_x;
        r_xf8.view_y <= r_xf7.view_y;
        r_xf8.view_z <= r_xf7.view_z;
        r_xf8.ir_x   <= r_xf7.ir_x;
        r_xf8.ir_y   <= r_xf7.ir_y;
        r_xf8.ir_z   <= r_xf7.ir_z;
        r_xf8.sz     <= r_xf7.sz;
        r_xf8.flags  <= r_xf7.flags;
        r_ovf8 <= r_ovf7;
        r_res8 <= s8_p[47:16];
    end

    // stage 9: saturate ratio
    logic [16:0] s9_ratio;
    always_comb begin
        if (r_ovf8 || r_res8 >= 32'(RATIO_MAX)) begin
            s9_ratio = RATIO_MAX;
        end else begin
            s9_ratio = r_res8[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.xf.valid <= 1'b0;
        end else begin
            r_out.xf.valid <= r_xf8.valid;
        end
        r_out.xf.view_x <= r_xf8.view_x;
        r_out.xf.view_y <= r_xf8.view_y;
        r_out.xf.view_z <= r_xf8.view_z;
        r_out.xf.ir_x   <= r_xf8.ir_x;
        r_out.xf.ir_y   <= r_xf8.ir_y;
        r_out.xf.ir_z   <= r_xf8.ir_z;
        r_out.xf.sz     <= r_xf8.sz;
        r_out.xf.flags  <= r_xf8.flags;
        r_out.ratio     <= s9_ratio;
    end

    assign o_div = r_out;

endmodule

FILE: hdl/vrtp_project.sv
// ----------------------------------------------------------------------------
// vrtp_project
// Screen X/Y and depth cue from the ratio, with final flag summary.
// Two register stages.
// ----------------------------------------------------------------------------
module vrtp_project (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  vrtp_pkg::t_div       i_div,
    input  logic signed [31:0]   i_ofx,
    input  logic signed [31:0]   i_ofy,
    input  logic signed [15:0]   i_dqa,
    input  logic signed [31:0]   i_dqb,
    output logic                 o_valid,
    output logic signed [10:0]   o_screen_x,
    output logic signed [10:0]   o_screen_y,
    output logic [15:0]          o_screen_z,
    output logic signed [15:0]   o_ir_x,
    output logic signed [15:0]   o_ir_y,
    output logic signed [15:0]   o_ir_z,
    output logic signed [31:0]   o_cue_mac,
    output logic [31:0]          o_error_flags,
    output logic signed [43:0]   o_view_x,
    output logic signed [43:0]   o_view_y,
    output logic signed [43:0]   o_view_z
);
    import vrtp_pkg::*;

    // stage 10
    t_xform             r_xf;
    logic signed [33:0] r_px, r_py, r_pd;
    logic signed [17:0] w_ratio;

    assign w_ratio = $signed({1'b0, i_div.ratio});

    // stage 10: three products with the ratio
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xf.valid <= 1'b0;
        end else begin
            r_xf.valid <= i_div.xf.valid;
        end
        r_xf.view_x <= i_div.xf.view_x;
        r_xf.view_y <= i_div.xf.view_y;
        r_xf.view_z <= i_div.xf.view_z;
        r_xf.ir_x   <= i_div.xf.ir_x;
        r_xf.ir_y   <= i_div.xf.ir_y;
        r_xf.ir_z   <= i_div.xf.ir_z;
        r_xf.sz     <= i_div.xf.sz;
        r_xf.flags  <= i_div.xf.flags;
        r_px <= 34'(i_div.xf.ir_x * w_ratio);
        r_py <= 34'(i_div.xf.ir_y * w_ratio);
        r_pd <= 34'(i_dqa * w_ratio);
    end

    // stage 11: offsets, clamps and flags
    logic signed [10:0] n_sx, n_sy;
    logic signed [31:0] n_dq;
    logic [31:0]        n_fl;

    always_comb begin
        logic signed [34:0] ex, ey, dq;
        logic signed [18:0] qx, qy;
        logic signed [22:0] q0;
        n_fl = r_xf.flags;
        ex = 35'(i_ofx) + 35'(r_px);
        ey = 35'(i_ofy) + 35'(r_py);
        dq = 35'(i_dqb) + 35'(r_pd);
        if (ex > 35'sh7fffffff || ey > 35'sh7fffffff || dq > 35'sh7fffffff)
            n_fl[FLAG_MAC0_POS] = 1'b1;
        if (ex < -35'sh80000000 || ey < -35'sh80000000 || dq < -35'sh80000000)
            n_fl[FLAG_MAC0_NEG] = 1'b1;
        qx = ex[34:16];
        qy = ey[34:16];
        if (qx < -19'sd1024) begin
            n_sx = -11'sd1024;
            n_fl[FLAG_SX] = 1'b1;
        end else if (qx > 19'sd1023) begin
            n_sx = 11'sd1023;
            n_fl[FLAG_SX] = 1'b1;
        end else begin
            n_sx = qx[10:0];
        end
        if (qy < -19'sd1024) begin
            n_sy = -11'sd1024;
            n_fl[FLAG_SY] = 1'b1;
        end else if (qy > 19'sd1023) begin
            n_sy = 11'sd1023;
            n_fl[FLAG_SY] = 1'b1;
        end else begin
            n_sy = qy[10:0];
        end
        q0 = dq[34:12];
        if (q0 < 23'sd0 || q0 > 23'sd4096) n_fl[FLAG_IR0] = 1'b1;
        n_dq = dq[31:0];
        if ((n_fl & FLAG_SUMMARY_MASK) != 32'd0) n_fl[FLAG_SUMMARY] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_xf.valid;
        end
        o_screen_x    <= n_sx;
        o_screen_y    <= n_sy;
        o_screen_z    <= r_xf.sz;
        o_ir_x        <= r_xf.ir_x;
        o_ir_y        <= r_xf.ir_y;
        o_ir_z        <= r_xf.ir_z;
        o_cue_mac     <= n_dq;
        o_error_flags <= n_fl;
        o_view_x      <= r_xf.view_x;
        o_view_y      <= r_xf.view_y;
        o_view_z      <= r_xf.view_z;
    end

endmodule

FILE: hdl/vertex_rotate_translate_project.sv
// ----------------------------------------------------------------------------
// vertex_rotate_translate_project
// Fixed-point vertex transform, perspective divide and depth cue.
// ----------------------------------------------------------------------------
// A vertex request is taken on any cycle with start high; busy never rises, so
// one vertex per clock is sustained. Each result appears on the o_ ports for a
// single cycle with o_valid high, after its request has passed every register
// stage below, in request order; the receiver cannot stall it.
// The path holds 11 register stages: four for matrix products and
// accumulation, five for the reciprocal divide, two for projection including
// the output registers.
// Configuration writes are always ready and must only be issued while no
// vertex is in flight.
module vertex_rotate_translate_project (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [15:0]   i_vertex_x,
    input  logic signed [15:0]   i_vertex_y,
    input  logic signed [15:0]   i_vertex_z,
    input  logic                 i_fraction_shift,
    input  logic                 i_limit_mode,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [3:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    output logic                 o_valid,
    output logic signed [10:0]   o_screen_x,
    output logic signed [10:0]   o_screen_y,
    output logic [15:0]          o_screen_z,
    output logic signed [15:0]   o_ir_x,
    output logic signed [15:0]   o_ir_y,
    output logic signed [15:0]   o_ir_z,
    output logic signed [31:0]   o_cue_mac,
    output logic [31:0]          o_error_flags,
    output logic signed [43:0]   o_view_x,
    output logic signed [43:0]   o_view_y,
    output logic signed [43:0]   o_view_z
);
    import vrtp_pkg::*;

    logic [47:0]        r_row0, r_row1, r_row2;
    logic [63:0]        r_trans_xy;
    logic signed [31:0] r_trans_z;
    logic [63:0]        r_screen_ofs;
    logic [31:0]        r_dist_slope;
    logic signed [31:0] r_cue_bias;

    t_xform w_xf;
    t_div   w_div;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0       <= '0;
            r_row1       <= '0;
            r_row2       <= '0;
            r_trans_xy   <= '0;
            r_trans_z    <= '0;
            r_screen_ofs <= '0;
            r_dist_slope <= '0;
            r_cue_bias   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ROT_ROW0:   r_row0       <= i_cfg_data[47:0];
                REG_ROT_ROW1:   r_row1       <= i_cfg_data[47:0];
                REG_ROT_ROW2:   r_row2       <= i_cfg_data[47:0];
                REG_TRANS_XY:   r_trans_xy   <= i_cfg_data;
                REG_TRANS_Z:    r_trans_z    <= i_cfg_data[31:0];
                REG_SCREEN_OFS: r_screen_ofs <= i_cfg_data;
                REG_DIST_SLOPE: r_dist_slope <= i_cfg_data[31:0];
                REG_CUE_BIAS:   r_cue_bias   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // rotation, translation, ir and sz
    vrtp_transform u_transform (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (start),
        .i_vertex_x       (i_vertex_x),
        .i_vertex_y       (i_vertex_y),
        .i_vertex_z       (i_vertex_z),
        .i_fraction_shift (i_fraction_shift),
        .i_limit_mode     (i_limit_mode),
        .i_row0           (r_row0),
        .i_row1           (r_row1),
        .i_row2           (r_row2),
        .i_tx             (r_trans_xy[31:0]),
        .i_ty             (r_trans_xy[63:32]),
        .i_tz             (r_trans_z),
        .o_xf             (w_xf)
    );

    // perspective divide
    vrtp_divide u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_xf    (w_xf),
        .i_h     (r_dist_slope[15:0]),
        .o_div   (w_div)
    );

    // screen projection and depth cue
    vrtp_project u_project (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_div         (w_div),
        .i_ofx         (r_screen_ofs[31:0]),
        .i_ofy         (r_screen_ofs[63:32]),
        .i_dqa         (r_dist_slope[31:16]),
        .i_dqb         (r_cue_bias),
        .o_valid       (o_valid),
        .o_screen_x    (o_screen_x),
        .o_screen_y    (o_screen_y),
        .o_screen_z    (o_screen_z),
        .o_ir_x        (o_ir_x),
        .o_ir_y        (o_ir_y),
        .o_ir_z        (o_ir_z),
        .o_cue_mac     (o_cue_mac),
        .o_error_flags (o_error_flags),
        .o_view_x      (o_view_x),
        .o_view_y      (o_view_y),
        .o_view_z      (o_view_z)
    );

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vertex transform and projection pipeline.
// A driver streams vertex requests from a queue with random idle bursts,
// a monitor compares every strobed result field by field against an
// in-bench fixed-point model. Configuration is rewritten between phases
// while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;
    import vrtp_pkg::*;

    typedef struct {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic               fsh;
        logic               lim;
    } t_vertex;

    typedef struct {
        logic [10:0] sx;
        logic [10:0] sy;
        logic [15:0] sz;
        logic [15:0] irx;
        logic [15:0] iry;
        logic [15:0] irz;
        logic [31:0] dq;
        logic [31:0] flags;
        logic [43:0] vwx;
        logic [43:0] vwy;
        logic [43:0] vwz;
    } t_proj;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic signed [15:0] i_vertex_x, i_vertex_y, i_vertex_z;
    logic        i_fraction_shift, i_limit_mode;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        o_valid;
    logic signed [10:0] o_screen_x, o_screen_y;
    logic [15:0] o_screen_z;
    logic signed [15:0] o_ir_x, o_ir_y, o_ir_z;
    logic signed [31:0] o_cue_mac;
    logic [31:0] o_error_flags;
    logic signed [43:0] o_view_x, o_view_y, o_view_z;

    vertex_rotate_translate_project i_dut (.*);

    // model copy of the registers
    logic [63:0] cfg_shadow [0:7];

    t_vertex vertex_queue[$];
    t_proj   proj_expected[$];
    int      err_count;
    int      result_count;
    int      gap_left;
    bit      idle_enable;
    logic [7:0] seed_rom [0:RECIP_TABLE_ENTRIES-1];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // seed table computed independently
    initial begin
        longint unsigned x, d7;
        int k;
        for (int idx = 0; idx < RECIP_TABLE_ENTRIES; idx++) begin
            k = (idx == RECIP_TABLE_ENTRIES - 1) ? RECIP_TABLE_ENTRIES - 2 : idx;
            d7 = 256 + k;
            x = 512;
            for (int i = 1; i < 5; i++)
                x = ((x * ((1024 * 512 - d7 * x) & 32'hffffffff)) & 32'hffffffff) >> 18;
            seed_rom[idx] = 8'((((x + 1) >> 1) - 257) & 8'hff);
        end
    end

    function automatic longint sx_w(longint v, int w);
        longint m;
        m = longint'(1) << (w - 1);
        v = v & ((m << 1) - 1);
        return (v ^ m) - m;
    endfunction

    function automatic longint recip_of(longint d);
        longint xr, t;
        xr = 257 + seed_rom[(((d & 16'h7fff) + 64) >> 7)];
        t = (-d * xr + 128) >>> 8;
        return (xr * (131072 + t) + 128) >>> 8;
    endfunction

    function automatic longint clampf(longint v, longint lo, longint hi, int bitn,
                                      ref logic [31:0] fl);
        if (v < lo || v > hi) begin
            fl[bitn] = 1'b1;
            return (v < lo) ? lo : hi;
        end
        return v;
    endfunction

    function automatic t_proj project_vertex(t_vertex vin);
        t_proj  p;
        logic [31:0] fl;
        longint v[3], tr[3], view[3], ir[3];
        longint acc, mac, fv, sz, e, sxv, syv, dq, hh, ratio, den, num, prod;
        int sh;
        fl = 0;
        v[0] = vin.vx; v[1] = vin.vy; v[2] = vin.vz;
        tr[0] = sx_w(cfg_shadow[REG_TRANS_XY], 32);
        tr[1] = sx_w(cfg_shadow[REG_TRANS_XY] >> 32, 32);
        tr[2] = sx_w(cfg_shadow[REG_TRANS_Z], 32);
        for (int r = 0; r < 3; r++) begin
            acc = tr[r] * 4096;
            for (int c = 0; c < 3; c++) begin
                acc = acc + sx_w(cfg_shadow[r] >> (16 * c), 16) * v[c];
                if (acc >= (longint'(1) << 43)) fl[FLAG_ACC_POS - r] = 1'b1;
                if (acc < -(longint'(1) << 43)) fl[FLAG_ACC_NEG - r] = 1'b1;
                acc = sx_w(acc, 44);
            end
            view[r] = acc;
        end
        for (int r = 0; r < 3; r++) begin
            mac = sx_w(view[r] >>> (vin.fsh ? 12 : 0), 32);
            fv = (r == 2) ? sx_w(view[r] >>> 12, 32) : mac;
            if (fv < -32768 || fv > 32767) fl[FLAG_IR - r] = 1'b1;
            if (mac < (vin.lim ? 0 : -32768)) mac = vin.lim ? 0 : -32768;
            if (mac > 32767) mac = 32767;
            ir[r] = mac;
        end
        sz = clampf(view[2] >>> 12, 0, 65535, FLAG_SZ, fl);
        hh = cfg_shadow[REG_DIST_SLOPE] & 16'hffff;
        // divide, overflow when 2*sz <= h
        if (sz * 2 <= hh) begin
            fl[FLAG_DIV] = 1'b1;
            ratio = 17'h1ffff;
        end else begin
            sh = 0;
            while (((sz << sh) & 16'h8000) == 0) sh++;
            num = hh << sh;
            den = (sz << sh) | 16'h8000;
            prod = num * recip_of(den & 16'hffff) + 32768;
            ratio = prod >> 16;
            if (ratio > 17'h1ffff) ratio = 17'h1ffff;
        end
        e = sx_w(cfg_shadow[REG_SCREEN_OFS], 32) + ir[0] * ratio;
        if (e < -(longint'(1) << 31)) fl[FLAG_MAC0_NEG] = 1'b1;
        if (e > (longint'(1) << 31) - 1) fl[FLAG_MAC0_POS] = 1'b1;
        sxv = clampf(e >>> 16, -1024, 1023, FLAG_SX, fl);
        e = sx_w(cfg_shadow[REG_SCREEN_OFS] >> 32, 32) + ir[1] * ratio;
        if (e < -(longint'(1) << 31)) fl[FLAG_MAC0_NEG] = 1'b1;
        if (e > (longint'(1) << 31) - 1) fl[FLAG_MAC0_POS] = 1'b1;
        syv = clampf(e >>> 16, -1024, 1023, FLAG_SY, fl);
        dq = sx_w(cfg_shadow[REG_CUE_BIAS], 32)
           + sx_w(cfg_shadow[REG_DIST_SLOPE] >> 16, 16) * ratio;
        if (dq < -(longint'(1) << 31)) fl[FLAG_MAC0_NEG] = 1'b1;
        if (dq > (longint'(1) << 31) - 1) fl[FLAG_MAC0_POS] = 1'b1;
        if ((dq >>> 12) < 0 || (dq >>> 12) > 4096) fl[FLAG_IR0] = 1'b1;
        if ((fl & FLAG_SUMMARY_MASK) != 0) fl[FLAG_SUMMARY] = 1'b1;
        p.sx = sxv[10:0]; p.sy = syv[10:0]; p.sz = sz[15:0];
        p.irx = ir[0][15:0]; p.iry = ir[1][15:0]; p.irz = ir[2][15:0];
        p.dq = dq[31:0]; p.flags = fl;
        p.vwx = view[0][43:0]; p.vwy = view[1][43:0]; p.vwz = view[2][43:0];
        return p;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want,
                 result_count);
        err_count++;
    endtask

    // driver: one request per accepted cycle, random idle bursts
    always @(posedge i_clk) begin
        t_vertex nv;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= 0;
            i_vertex_x <= '0; i_vertex_y <= '0; i_vertex_z <= '0;
            i_fraction_shift <= 1'b0; i_limit_mode <= 1'b0;
        end else if (start && !busy) begin
            proj_expected.push_back(project_vertex(vertex_queue.pop_front()));
            if (vertex_queue.size() > 0 && (!idle_enable || $urandom_range(0, 9) != 0)) begin
                nv = vertex_queue[0];
                i_vertex_x <= nv.vx; i_vertex_y <= nv.vy; i_vertex_z <= nv.vz;
                i_fraction_shift <= nv.fsh; i_limit_mode <= nv.lim;
            end else begin
                start <= 1'b0;
                gap_left <= (vertex_queue.size() > 0) ? $urandom_range(0, 12) : 0;
            end
        end else if (!start && vertex_queue.size() > 0) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else begin
                nv = vertex_queue[0];
                i_vertex_x <= nv.vx; i_vertex_y <= nv.vy; i_vertex_z <= nv.vz;
                i_fraction_shift <= nv.fsh; i_limit_mode <= nv.lim;
                start <= 1'b1;
            end
        end
    end

    // monitor: compare each strobed result against the oldest prediction
    always @(posedge i_clk) begin
        t_proj w;
        if (i_rst_n && o_valid) begin
            if (proj_expected.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                w = proj_expected.pop_front();
                if (o_screen_x !== w.sx) report_mismatch("screen_x", o_screen_x, w.sx);
                if (o_screen_y !== w.sy) report_mismatch("screen_y", o_screen_y, w.sy);
                if (o_screen_z !== w.sz) report_mismatch("screen_z", o_screen_z, w.sz);
                if (o_ir_x !== w.irx) report_mismatch("ir_x", o_ir_x, w.irx);
                if (o_ir_y !== w.iry) report_mismatch("ir_y", o_ir_y, w.iry);
                if (o_ir_z !== w.irz) report_mismatch("ir_z", o_ir_z, w.irz);
                if (o_cue_mac !== w.dq) report_mismatch("cue_mac", o_cue_mac, w.dq);
                if (o_error_flags !== w.flags)
                    report_mismatch("error_flags", o_error_flags, w.flags);
                if (o_view_x !== w.vwx) report_mismatch("view_x", o_view_x, w.vwx);
                if (o_view_y !== w.vwy) report_mismatch("view_y", o_view_y, w.vwy);
                if (o_view_z !== w.vwz) report_mismatch("view_z", o_view_z, w.vwz);
            end
            result_count++;
        end
    end

    // register write over the config channel, pipeline must be empty
    task automatic write_reg(logic [3:0] idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx < 8) cfg_shadow[idx] = val;
    endtask

    function automatic logic [15:0] rand16(int mode);
        case (mode)
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 8192)) - 16'd4096;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic setup_phase(int kind);
        logic [63:0] rows [3];
        for (int r = 0; r < 3; r++) begin
            case (kind)
                0: rows[r] = 64'(16'h1000) << (16 * r);     // identity
                1: rows[r] = {16'h7fff, 16'h7fff, 16'h7fff};
                2: rows[r] = {16'h8000, 16'h8000, 16'h8000};
                default: rows[r] = {rand16($urandom_range(0, 3)), rand16($urandom_range(0, 3)),
                                    rand16($urandom_range(0, 3))};
            endcase
            write_reg(4'(r), rows[r]);
        end
        case (kind)
            0: begin
                write_reg(REG_TRANS_XY, 64'd0);
                write_reg(REG_TRANS_Z, 64'd1000);
                write_reg(REG_SCREEN_OFS, {32'd160 << 16, 32'd120 << 16});
                write_reg(REG_DIST_SLOPE, {32'hffff_0000 | 32'd200});
                write_reg(REG_CUE_BIAS, 64'h0100_0000);
            end
            1: begin
                write_reg(REG_TRANS_XY, {32'h7fffffff, 32'h7fffffff});
                write_reg(REG_TRANS_Z, 64'h7fffffff);
                write_reg(REG_SCREEN_OFS, {32'h7fffffff, 32'h7fffffff});
                write_reg(REG_DIST_SLOPE, 64'hffffffff);
                write_reg(REG_CUE_BIAS, 64'h7fffffff);
            end
            2: begin
                write_reg(REG_TRANS_XY, {32'h80000000, 32'h80000000});
                write_reg(REG_TRANS_Z, 64'h80000000);
                write_reg(REG_SCREEN_OFS, {32'h80000000, 32'h80000000});
                write_reg(REG_DIST_SLOPE, 64'h80000000);
                write_reg(REG_CUE_BIAS, 64'h80000000);
            end
            default: begin
                write_reg(REG_TRANS_XY, {32'($urandom_range(0, 4000)) - 32'd2000,
                                         32'($urandom_range(0, 4000)) - 32'd2000});
                write_reg(REG_TRANS_Z, $urandom_range(0, 3) == 0 ? 64'($urandom)
                                                                 : 64'($urandom_range(0, 30000)));
                write_reg(REG_SCREEN_OFS, {32'($urandom), 32'($urandom)});
                write_reg(REG_DIST_SLOPE, {32'($urandom) & 32'hffff0000
                                           | 32'($urandom_range(0, 65535))});
                write_reg(REG_CUE_BIAS, 64'($urandom));
            end
        endcase
        write_reg(4'd9, 64'hdead);   // unused index, dropped
    endtask

    task automatic add_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                              logic f, logic l);
        t_vertex nv;
        nv.vx = x; nv.vy = y; nv.vz = z; nv.fsh = f; nv.lim = l;
        vertex_queue.push_back(nv);
    endtask

    task automatic drain();
        while (vertex_queue.size() > 0 || proj_expected.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        int phases;
        err_count = 0; result_count = 0; idle_enable = 1;
        for (int i = 0; i < 8; i++) cfg_shadow[i] = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 0; i_cfg_index = 0; i_cfg_data = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        // reset config: sz zero, divide overflow
        add_vertex(16'd0, 16'd0, 16'd0, 1'b1, 1'b0);
        add_vertex(16'h7fff, 16'h8000, 16'h7fff, 1'b0, 1'b1);
        drain();
        // directed extremes under identity, max and min settings
        for (int k = 0; k < 3; k++) begin
            setup_phase(k);
            add_vertex(16'h7fff, 16'h7fff, 16'h7fff, 1'b1, 1'b0);
            add_vertex(16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b1);
            add_vertex(16'h7fff, 16'h8000, 16'h7fff, 1'b0, 1'b0);
            add_vertex(16'h8000, 16'h7fff, 16'h8000, 1'b0, 1'b1);
            add_vertex(16'd100, 16'hff9c, 16'd50, 1'b1, 1'b0);
            add_vertex(16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
            add_vertex(16'd1, 16'hffff, 16'd300, 1'b1, 1'b1);
            drain();
        end
        // random phases, last stretch runs back to back
        phases = 20;
        for (int p = 0; p < phases; p++) begin
            if (p == phases - 2) idle_enable = 0;
            setup_phase((p % 7 == 3) ? $urandom_range(0, 2) : 3);
            for (int n = 0; n < 96; n++)
                add_vertex($urandom_range(0, 1) ? rand16($urandom_range(0, 3))
                                                : 16'($urandom_range(0, 2000)) - 16'd1000,
                           rand16($urandom_range(0, 3)), rand16($urandom_range(0, 3)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            drain();
        end
        $display("covered %0d vertex results over %0d register settings", result_count,
                 phases + 4);
        if (err_count == 0 && proj_expected.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: files.f
hdl/vrtp_pkg.sv
hdl/vrtp_transform.sv
hdl/vrtp_divide.sv
hdl/vrtp_project.sv
hdl/vertex_rotate_translate_project.sv
tb/sv/tb_top.sv
